### hw/rtl/nbfc_pkg.sv
`default_nettype none
package nbfc_pkg;

  localparam int MAX_CLS   = 16;
  localparam int NUM_FEAT  = 11;
  localparam int TAB_CLS   = 9;
  localparam int CLS_W     = 4;
  localparam int COST_W    = 16;
  localparam int WEIGHT_W  = 17;
  localparam int SUM_W     = 21;
  localparam int QUOT_W    = 17;

  // feature bit positions
  localparam int F_ZERO    = 0;
  localparam int F_KPTR    = 1;
  localparam int F_LOWENT  = 2;
  localparam int F_HIGHENT = 3;
  localparam int F_SMALL   = 4;
  localparam int F_SPARSE  = 5;
  localparam int F_POOLTAG = 6;
  localparam int F_SYMBOL  = 7;
  localparam int F_LIST    = 8;
  localparam int F_UNICODE = 9;
  localparam int F_ASCII   = 10;

  localparam logic [CLS_W-1:0] CLS_UNKNOWN = 4'd0;
  localparam logic [CLS_W-1:0] IDX_ASCII   = 4'd4;

  typedef struct packed {
    logic [63:0] raw_value;
    logic [15:0] bytes_remaining;
    logic        pool_tag_valid;
    logic        symbol_resolves;
    logic        list_entry_found;
    logic        unicode_string_found;
    logic [11:0] ascii_run_len;
  } nbfc_in_t;

  typedef struct packed {
    logic [3:0]  field_class;
    logic [15:0] confidence;
    logic [12:0] field_size;
    logic        is_kernel_pointer;
    logic [63:0] stripped_pointer;
  } nbfc_out_t;

  // word side info carried along the scoring pipeline
  typedef struct packed {
    logic        short_buf;
    logic        kptr;
    logic [63:0] strip;
    logic [11:0] run;
    logic        ascii_feat;
    logic [2:0]  remain_lo;
  } nbfc_tag_t;

  // word handed from scoring to the back end
  typedef struct packed {
    nbfc_tag_t            tag;
    logic [CLS_W-1:0]     best;
    logic [SUM_W-1:0]     sum;
  } nbfc_mid_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nbfc_qstat_t;

  localparam int PRIOR_TAB [0:TAB_CLS-1] = '{200, 50, 50, 300, 50, 50, 50, 100, 150};
  localparam int SIZE_TAB  [0:TAB_CLS-1] = '{8, 16, 16, 8, 8, 4, 8, 4, 4};

  localparam int P_TAB [0:TAB_CLS-1][0:NUM_FEAT-1] = '{
    '{950, 10, 900, 10, 50, 10, 10, 1, 1, 1, 10},
    '{1, 990, 100, 800, 1, 100, 1, 800, 990, 1, 10},
    '{1, 50, 100, 500, 100, 100, 10, 10, 1, 990, 10},
    '{1, 990, 100, 800, 1, 100, 10, 800, 1, 1, 10},
    '{1, 10, 100, 500, 10, 100, 10, 1, 1, 1, 990},
    '{1, 10, 100, 500, 10, 100, 990, 1, 1, 1, 950},
    '{1, 10, 800, 10, 600, 100, 10, 1, 1, 1, 10},
    '{50, 10, 800, 100, 200, 900, 10, 1, 1, 1, 10},
    '{10, 10, 500, 500, 500, 500, 10, 1, 1, 1, 10}
  };

  // 2^(-k/16) in Q16
  localparam logic [WEIGHT_W-1:0] EXP_TAB [0:16] = '{
    17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
    17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
    17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
  };

  function automatic logic [11:0] cost_of(int pm);
    logic [11:0] c;
    case (pm)
      1:       c = 12'd2551;
      10:      c = 12'd1701;
      50:      c = 12'd1106;
      100:     c = 12'd850;
      150:     c = 12'd701;
      200:     c = 12'd594;
      300:     c = 12'd445;
      400:     c = 12'd338;
      500:     c = 12'd256;
      600:     c = 12'd189;
      800:     c = 12'd82;
      900:     c = 12'd39;
      950:     c = 12'd19;
      990:     c = 12'd4;
      999:     c = 12'd0;
      1000:    c = 12'd0;
      default: c = 12'd4095;
    endcase
    return c;
  endfunction

  function automatic int cls_p(int c, int f);
    return (c < TAB_CLS) ? P_TAB[c][f] : 0;
  endfunction

  function automatic logic [11:0] prior_cost(int c);
    return cost_of((c < TAB_CLS) ? PRIOR_TAB[c] : 0);
  endfunction

  function automatic logic [12:0] cls_size(int c);
    return (c < TAB_CLS) ? 13'(SIZE_TAB[c]) : 13'd0;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/nbfc_front.sv
`default_nettype none
module nbfc_front import nbfc_pkg::*; #(
  parameter int CLASS_COUNT = 9
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      acc,
  input  wire nbfc_in_t  in_word,
  input  wire logic      en,
  output logic           push,
  output nbfc_mid_t      push_word
);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [CLS_W-1:0]  idx;
  } cand_t;

  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.cost < a.cost) ? b : a;
  endfunction

  function automatic logic [WEIGHT_W-1:0] weight_of(logic [COST_W-1:0] d);
    logic [7:0]          q;
    logic [3:0]          hi;
    logic [3:0]          lo;
    logic [WEIGHT_W-1:0] a;
    logic [WEIGHT_W-1:0] b;
    logic [11:0]         df;
    logic [16:0]         prod;
    logic [WEIGHT_W-1:0] v;
    q    = d[15:8];
    hi   = d[7:4];
    lo   = d[3:0];
    a    = EXP_TAB[hi];
    b    = EXP_TAB[5'({1'b0, hi} + 5'd1)];
    df   = 12'(a - b);
    prod = 17'(df * lo) + 17'd8;
    v    = a - 17'(prod >> 4);
    return (q > 8'd16) ? '0 : (v >> q[4:0]);
  endfunction

  // stage 1: features
  logic                v1_r;
  logic [NUM_FEAT-1:0] feat1_r;
  nbfc_tag_t           tag1_r;

  logic [NUM_FEAT-1:0] feat_nxt;
  nbfc_tag_t           tag_nxt;

  always_comb begin
    logic [63:0] raw;
    logic [15:0] remain;
    logic [11:0] run;
    logic [63:0] strip;
    logic        kptr;
    logic        small_int;
    logic        lowent;
    logic [3:0]  distinct;
    logic [6:0]  pop;
    logic [3:0]  cnt;
    logic        first;
    raw    = in_word.raw_value;
    remain = in_word.bytes_remaining;
    strip  = raw[55] ? (raw | {16'hFFFF, 48'h0}) : raw;
    kptr   = (strip[63:48] == 16'hFFFF) && (strip != '1);
    run    = ({4'h0, in_word.ascii_run_len} > remain) ? remain[11:0] : in_word.ascii_run_len;
    small_int = (raw != 64'h0) && (raw[63:16] == 48'h0);
    lowent   = 1'b0;
    distinct = '0;
    for (int i = 0; i < 8; i++) begin
      cnt   = '0;
      first = 1'b1;
      for (int j = 0; j < 8; j++) begin
        if (raw[8*j +: 8] == raw[8*i +: 8]) begin
          cnt = cnt + 4'd1;
          if (j < i) first = 1'b0;
        end
      end
      if (cnt >= 4'd7) lowent = 1'b1;
      if (first) distinct = distinct + 4'd1;
    end
    pop = '0;
    for (int k = 0; k < 64; k++) pop = pop + 7'(raw[k]);
    feat_nxt[F_ZERO]    = (raw == 64'h0);
    feat_nxt[F_KPTR]    = kptr;
    feat_nxt[F_LOWENT]  = lowent;
    feat_nxt[F_HIGHENT] = (distinct >= 4'd7);
    feat_nxt[F_SMALL]   = small_int;
    feat_nxt[F_SPARSE]  = (pop >= 7'd1) && (pop <= 7'd12) && !small_int;
    feat_nxt[F_POOLTAG] = in_word.pool_tag_valid;
    feat_nxt[F_SYMBOL]  = kptr && in_word.symbol_resolves;
    feat_nxt[F_LIST]    = kptr && in_word.list_entry_found && (remain >= 16'd16);
    feat_nxt[F_UNICODE] = in_word.unicode_string_found && (remain >= 16'd16);
    feat_nxt[F_ASCII]   = (run >= 12'd4);
    tag_nxt.short_buf   = (remain < 16'd8);
    tag_nxt.kptr        = kptr;
    tag_nxt.strip       = strip;
    tag_nxt.run         = run;
    tag_nxt.ascii_feat  = feat_nxt[F_ASCII];
    tag_nxt.remain_lo   = remain[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= acc;
    end
    if (en) begin
      feat1_r <= feat_nxt;
      tag1_r  <= tag_nxt;
    end
  end

  // stage 2: class costs, unused classes never win
  logic              v2_r;
  nbfc_tag_t         tag2_r;
  logic [COST_W-1:0] cost2_r [0:MAX_CLS-1];
  logic [COST_W-1:0] cost_nxt [0:MAX_CLS-1];

  always_comb begin
    for (int c = 0; c < MAX_CLS; c++) begin
      cost_nxt[c] = 16'(prior_cost(c));
      for (int f = 0; f < NUM_FEAT; f++) begin
        cost_nxt[c] = cost_nxt[c] + 16'(feat1_r[f] ? cost_of(cls_p(c, f))
                                                   : cost_of(1000 - cls_p(c, f)));
      end
      if (c >= CLASS_COUNT) cost_nxt[c] = '1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      tag2_r  <= tag1_r;
      cost2_r <= cost_nxt;
    end
  end

  // stage 3: minimum over groups of four
  logic              v3_r;
  nbfc_tag_t         tag3_r;
  logic [COST_W-1:0] cost3_r [0:MAX_CLS-1];
  cand_t             grp3_r [0:3];
  cand_t             grp_nxt [0:3];

  always_comb begin
    cand_t c0, c1, c2, c3;
    for (int g = 0; g < 4; g++) begin
      c0 = '{cost: cost2_r[4*g],   idx: CLS_W'(4*g)};
      c1 = '{cost: cost2_r[4*g+1], idx: CLS_W'(4*g+1)};
      c2 = '{cost: cost2_r[4*g+2], idx: CLS_W'(4*g+2)};
      c3 = '{cost: cost2_r[4*g+3], idx: CLS_W'(4*g+3)};
      grp_nxt[g] = pick(pick(c0, c1), pick(c2, c3));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      tag3_r  <= tag2_r;
      cost3_r <= cost2_r;
      grp3_r  <= grp_nxt;
    end
  end

  // stage 4: overall minimum, earliest class on a tie
  logic              v4_r;
  nbfc_tag_t         tag4_r;
  logic [COST_W-1:0] cost4_r [0:MAX_CLS-1];
  cand_t             best4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
    if (en) begin
      tag4_r  <= tag3_r;
      cost4_r <= cost3_r;
      best4_r <= pick(pick(grp3_r[0], grp3_r[1]), pick(grp3_r[2], grp3_r[3]));
    end
  end

  // stage 5: relative weights
  logic                v5_r;
  nbfc_tag_t           tag5_r;
  logic [CLS_W-1:0]    best5_r;
  logic [WEIGHT_W-1:0] w5_r [0:MAX_CLS-1];
  logic [WEIGHT_W-1:0] w_nxt [0:MAX_CLS-1];

  always_comb begin
    for (int c = 0; c < MAX_CLS; c++) begin
      w_nxt[c] = (c < CLASS_COUNT) ? weight_of(cost4_r[c] - best4_r.cost) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
    if (en) begin
      tag5_r  <= tag4_r;
      best5_r <= best4_r.idx;
      w5_r    <= w_nxt;
    end
  end

  // stage 6: partial sums of four
  logic             v6_r;
  nbfc_tag_t        tag6_r;
  logic [CLS_W-1:0] best6_r;
  logic [18:0]      ps6_r [0:3];
  logic [18:0]      ps_nxt [0:3];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      ps_nxt[g] = 19'(w5_r[4*g]) + 19'(w5_r[4*g+1]) + 19'(w5_r[4*g+2]) + 19'(w5_r[4*g+3]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
    if (en) begin
      tag6_r  <= tag5_r;
      best6_r <= best5_r;
      ps6_r   <= ps_nxt;
    end
  end

  // stage 7: total weight
  logic      v7_r;
  nbfc_mid_t mid7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en) begin
      v7_r <= v6_r;
    end
    if (en) begin
      mid7_r.tag  <= tag6_r;
      mid7_r.best <= best6_r;
      mid7_r.sum  <= 21'(ps6_r[0]) + 21'(ps6_r[1]) + 21'(ps6_r[2]) + 21'(ps6_r[3]);
    end
  end

  assign push      = v7_r && en;
  assign push_word = mid7_r;

endmodule
`default_nettype wire

### hw/rtl/nbfc_queue.sv
`default_nettype none
module nbfc_queue import nbfc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire nbfc_mid_t   push_word,
  input  wire logic        pop,
  output nbfc_mid_t        head,
  output nbfc_qstat_t      stat
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  nbfc_mid_t         mem_r [0:DEPTH-1];
  logic [PTR_W-1:0]  wr_r, wr_nxt;
  logic [PTR_W-1:0]  rd_r, rd_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_nxt    = push ? PTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt    = pop ? PTR_W'(rd_r + 1'b1) : rd_r;
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
    if (push) mem_r[wr_r] <= push_word;
  end

  assign head       = mem_r[rd_r];
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CNT_W'(DEPTH)) || pop)
    else $error("word pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("word popped from empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r == CNT_W'($past(count_r) + CNT_W'($past(push))
                                       - CNT_W'($past(pop))))
    else $error("queue count out of step with pushes and pops");
`endif

endmodule
`default_nettype wire

### hw/rtl/nbfc_back.sv
`default_nettype none
module nbfc_back import nbfc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire nbfc_mid_t  head,
  input  wire nbfc_qstat_t stat,
  output logic            pop,
  output logic            out_valid,
  output nbfc_out_t       out_data
);

  localparam int STEPS = QUOT_W;
  localparam int REM_W = 33;
  localparam int TRY_W = SUM_W + STEPS;

  logic              dv_v   [0:STEPS];
  logic [REM_W-1:0]  dv_rem [0:STEPS];
  logic [QUOT_W-1:0] dv_q   [0:STEPS];
  nbfc_mid_t         dv_m   [0:STEPS];

  // back end never stalls, so the head is taken whenever present
  assign pop       = !stat.empty;
  assign dv_v[0]   = pop;
  assign dv_rem[0] = 33'h1_0000_0000;
  assign dv_q[0]   = '0;
  assign dv_m[0]   = head;

  // restoring division of 2^32 by the weight sum, one quotient bit a stage
  for (genvar s = 0; s < STEPS; s++) begin : g_div
    localparam int K = STEPS - 1 - s;
    logic [TRY_W-1:0] trial;
    logic             ge;
    always_comb begin
      trial = TRY_W'(dv_m[s].sum) << K;
      ge    = ({(TRY_W - REM_W)'(0), dv_rem[s]} >= trial);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[s+1] <= 1'b0;
      end else begin
        dv_v[s+1] <= dv_v[s];
      end
      dv_rem[s+1] <= ge ? REM_W'(dv_rem[s] - trial[REM_W-1:0]) : dv_rem[s];
      dv_q[s+1]   <= dv_q[s] | (ge ? (QUOT_W'(1) << K) : '0);
      dv_m[s+1]   <= dv_m[s];
    end
  end

  logic      out_valid_r;
  nbfc_out_t out_r;
  nbfc_out_t out_nxt;

  always_comb begin
    nbfc_mid_t m;
    m = dv_m[STEPS];
    if (m.tag.short_buf) begin
      out_nxt.field_class       = CLS_UNKNOWN;
      out_nxt.confidence        = '0;
      out_nxt.field_size        = {10'h0, m.tag.remain_lo};
      out_nxt.is_kernel_pointer = 1'b0;
      out_nxt.stripped_pointer  = '0;
    end else begin
      out_nxt.field_class       = CLS_W'(m.best + 1'b1);
      out_nxt.confidence        = dv_q[STEPS][16] ? 16'hFFFF : dv_q[STEPS][15:0];
      out_nxt.field_size        = cls_size(int'(m.best));
      if (m.tag.ascii_feat && (m.best == IDX_ASCII)) begin
        out_nxt.field_size = 13'({1'b0, m.tag.run} + 13'd7) & ~13'd7;
      end
      out_nxt.is_kernel_pointer = m.tag.kptr;
      out_nxt.stripped_pointer  = m.tag.strip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v[STEPS];
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### hw/rtl/naive_bayes_field_classifier.sv
// Naive Bayes field classifier: scores one 64-bit memory word against the
// field classes and reports the winner, its confidence and its size.
//
// Input: drive in_data and raise start; the word is taken at a rising edge
// where start is high and busy is low. Words may follow every cycle.
// Output: each word gives exactly one result, shown on out_data for one
// cycle with out_valid high, in input order. Throughput is one word per
// cycle.
// The front scores the word in seven register stages (features, class
// costs, two-level minimum tree, weights, two-level sum); a four-word queue
// feeds the back, a 17-stage restoring divider for the confidence and one
// output register.
// The receiver cannot stall: the back drains the queue every cycle, so the
// queue never holds more than one word and busy stays low.
// Reset (rst_n low, synchronous) drops every word in flight; no result is
// produced for words accepted before reset.
`default_nettype none
module naive_bayes_field_classifier import nbfc_pkg::*; #(
  parameter int CLASS_COUNT = 9
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire nbfc_in_t  in_data,
  output logic           out_valid,
  output nbfc_out_t      out_data
);

  nbfc_qstat_t qstat;
  logic        push;
  logic        pop;
  nbfc_mid_t   push_word;
  nbfc_mid_t   head;

  assign busy = qstat.full;

  nbfc_front #(.CLASS_COUNT(CLASS_COUNT)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (start && !busy),
    .in_word   (in_data),
    .en        (!qstat.full),
    .push      (push),
    .push_word (push_word)
  );

  nbfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .stat      (qstat)
  );

  nbfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (qstat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_conf_zero_short: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.confidence == 16'h0) |-> out_data.field_class == CLS_UNKNOWN)
    else $error("zero confidence on a classified word");
`endif

endmodule
`default_nettype wire
